@@ rtl/core/ctm_pkg.sv @@
// Shared types and constants of the color tolerance mask pipeline.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package ctm_pkg;

   localparam int TILE_SIZE       = 64;
   localparam int MASK_SIZE       = 4096;
   localparam int COLOR_TOLERANCE = 3276;

   localparam logic [15:0] FX_ONE = 16'h8000;

   localparam int DIV_STEPS       = 15;
   localparam int DIV_STAGES      = 3;
   localparam int STEPS_PER_STAGE = DIV_STEPS / DIV_STAGES;

   // hit test: (dist << 15) / tol < 1.5  <=>  2 * dist < 3 * tol
   localparam logic [17:0] TOL_LIMIT = 18'(3 * COLOR_TOLERANCE);

   localparam int NUM_STAGES = DIV_STAGES + 3;

   typedef enum logic [2:0] {
      REG_TARGET_RED      = 3'd0,
      REG_TARGET_GREEN    = 3'd1,
      REG_TARGET_BLUE     = 3'd2,
      REG_ALPHA_THRESHOLD = 3'd3,
      REG_INVERT_MATCH    = 3'd4,
      REG_MARK_VALUE      = 3'd5,
      REG_ORIGIN_X        = 3'd6,
      REG_ORIGIN_Y        = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [15:0] pixel_red;
      logic [15:0] pixel_green;
      logic [15:0] pixel_blue;
      logic [15:0] pixel_alpha;
      logic [5:0]  tile_col;
      logic [5:0]  tile_row;
   } req_type;

   typedef struct packed {
      logic        write_mark;
      logic [7:0]  mark_byte;
      logic [11:0] dest_col;
      logic [11:0] dest_row;
   } rsp_type;

   typedef struct packed {
      logic [15:0] target_red;
      logic [15:0] target_green;
      logic [15:0] target_blue;
      logic [15:0] alpha_threshold;
      logic        invert_match;
      logic [7:0]  mark_value;
      logic [11:0] origin_x;
      logic [11:0] origin_y;
   } cfg_type;

   typedef struct packed {
      logic        sat;
      logic [15:0] rem;
      logic [14:0] quo;
   } div_lane_type;

   typedef struct packed {
      logic [15:0]            divisor;
      logic                   zero_alpha;
      logic                   alpha_ok;
      logic [15:0]            alpha_dist;
      logic [11:0]            dest_col;
      logic [11:0]            dest_row;
      div_lane_type [2:0]     lane;
   } div_work_type;

endpackage

`default_nettype wire

@@ rtl/core/ctm_csr.sv @@
// Configuration registers of the color tolerance mask behind an APB-style port.
// Depends on ctm_pkg for the register index codes and the cfg_type struct.
`default_nettype none

module ctm_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [4:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output logic      [31:0]      prdata,
   output logic                  pready,
   output ctm_pkg::cfg_type      cfg
);

   ctm_pkg::cfg_type       cfg_ff;
   ctm_pkg::cfg_type       cfg_in;
   ctm_pkg::reg_index_type index;

   assign index  = ctm_pkg::reg_index_type'(paddr[4:2]);
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (index)
            ctm_pkg::REG_TARGET_RED:      cfg_in.target_red      = pwdata[15:0];
            ctm_pkg::REG_TARGET_GREEN:    cfg_in.target_green    = pwdata[15:0];
            ctm_pkg::REG_TARGET_BLUE:     cfg_in.target_blue     = pwdata[15:0];
            ctm_pkg::REG_ALPHA_THRESHOLD: cfg_in.alpha_threshold = pwdata[15:0];
            ctm_pkg::REG_INVERT_MATCH:    cfg_in.invert_match    = pwdata[0];
            ctm_pkg::REG_MARK_VALUE:      cfg_in.mark_value      = pwdata[7:0];
            ctm_pkg::REG_ORIGIN_X:        cfg_in.origin_x        = pwdata[11:0];
            ctm_pkg::REG_ORIGIN_Y:        cfg_in.origin_y        = pwdata[11:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_red      <= 16'd0;
         cfg_ff.target_green    <= 16'd0;
         cfg_ff.target_blue     <= 16'd0;
         cfg_ff.alpha_threshold <= ctm_pkg::FX_ONE;
         cfg_ff.invert_match    <= 1'b0;
         cfg_ff.mark_value      <= 8'd1;
         cfg_ff.origin_x        <= 12'd0;
         cfg_ff.origin_y        <= 12'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (index)
         ctm_pkg::REG_TARGET_RED:      prdata = {16'd0, cfg_ff.target_red};
         ctm_pkg::REG_TARGET_GREEN:    prdata = {16'd0, cfg_ff.target_green};
         ctm_pkg::REG_TARGET_BLUE:     prdata = {16'd0, cfg_ff.target_blue};
         ctm_pkg::REG_ALPHA_THRESHOLD: prdata = {16'd0, cfg_ff.alpha_threshold};
         ctm_pkg::REG_INVERT_MATCH:    prdata = {31'd0, cfg_ff.invert_match};
         ctm_pkg::REG_MARK_VALUE:      prdata = {24'd0, cfg_ff.mark_value};
         ctm_pkg::REG_ORIGIN_X:        prdata = {20'd0, cfg_ff.origin_x};
         ctm_pkg::REG_ORIGIN_Y:        prdata = {20'd0, cfg_ff.origin_y};
         default:                      prdata = 32'd0;
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/core/ctm_front.sv @@
// First pipeline stage: threshold test, divider setup and destination address.
// Depends on ctm_pkg for the request, configuration and divider work structs.
`default_nettype none

module ctm_front (
   input  wire logic                clock,
   input  wire logic                load,
   input  wire ctm_pkg::req_type    req,
   input  wire ctm_pkg::cfg_type    cfg,
   output ctm_pkg::div_work_type    work
);

   ctm_pkg::div_work_type work_ff;
   ctm_pkg::div_work_type work_in;
   logic [15:0]           chan [3];
   logic [12:0]           col_sum;
   logic [12:0]           row_sum;

   assign chan[0] = req.pixel_red;
   assign chan[1] = req.pixel_green;
   assign chan[2] = req.pixel_blue;

   assign col_sum = {1'b0, cfg.origin_x} + 13'(req.tile_col % ctm_pkg::TILE_SIZE);
   assign row_sum = {1'b0, cfg.origin_y} + 13'(req.tile_row % ctm_pkg::TILE_SIZE);

   always_comb begin
      work_in.divisor    = req.pixel_alpha;
      work_in.zero_alpha = (req.pixel_alpha == 16'd0);
      work_in.alpha_ok   = (req.pixel_alpha >= cfg.alpha_threshold);
      work_in.alpha_dist = (req.pixel_alpha >= ctm_pkg::FX_ONE) ? 16'd0
                         : 16'(ctm_pkg::FX_ONE - req.pixel_alpha);
      work_in.dest_col   = 12'(col_sum % ctm_pkg::MASK_SIZE);
      work_in.dest_row   = 12'(row_sum % ctm_pkg::MASK_SIZE);
      for (int ch = 0; ch < 3; ch++) begin
         work_in.lane[ch].sat = (chan[ch] >= req.pixel_alpha);
         work_in.lane[ch].rem = chan[ch];
         work_in.lane[ch].quo = 15'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         work_ff <= work_in;
      end
   end

   assign work = work_ff;

endmodule

`default_nettype wire

@@ rtl/core/ctm_div_stage.sv @@
// One stage of the pipelined restoring divider, several quotient bits per lane.
// Depends on ctm_pkg for the divider work struct and the step count per stage.
`default_nettype none

module ctm_div_stage (
   input  wire logic                   clock,
   input  wire logic                   load,
   input  wire ctm_pkg::div_work_type  work_i,
   output ctm_pkg::div_work_type       work_o
);

   ctm_pkg::div_work_type work_ff;
   ctm_pkg::div_work_type work_in;
   logic [16:0]           trial;

   always_comb begin
      work_in = work_i;
      trial   = 17'd0;
      for (int ch = 0; ch < 3; ch++) begin
         for (int s = 0; s < ctm_pkg::STEPS_PER_STAGE; s++) begin
            trial = {work_in.lane[ch].rem, 1'b0};
            if (trial >= {1'b0, work_in.divisor}) begin
               work_in.lane[ch].rem = 16'(trial - {1'b0, work_in.divisor});
               work_in.lane[ch].quo = {work_in.lane[ch].quo[13:0], 1'b1};
            end else begin
               work_in.lane[ch].rem = trial[15:0];
               work_in.lane[ch].quo = {work_in.lane[ch].quo[13:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         work_ff <= work_in;
      end
   end

   assign work_o = work_ff;

endmodule

`default_nettype wire

@@ rtl/core/ctm_back.sv @@
// Last two stages: channel distance and maximum, then tolerance test and response.
// Depends on ctm_pkg for the work, configuration and response structs.
`default_nettype none

module ctm_back (
   input  wire logic                   clock,
   input  wire logic [1:0]             load,
   input  wire ctm_pkg::div_work_type  work,
   input  wire ctm_pkg::cfg_type       cfg,
   output ctm_pkg::rsp_type            rsp
);

   logic [15:0]      target [3];
   logic [15:0]      pix    [3];
   logic [15:0]      diff   [3];
   logic [15:0]      dist_in;
   logic [15:0]      dist_ff;
   logic             alpha_ok_ff;
   logic [11:0]      dest_col_ff;
   logic [11:0]      dest_row_ff;
   logic             hit;
   logic             write;
   ctm_pkg::rsp_type rsp_ff;
   ctm_pkg::rsp_type rsp_in;

   assign target[0] = (cfg.target_red   > ctm_pkg::FX_ONE) ? ctm_pkg::FX_ONE : cfg.target_red;
   assign target[1] = (cfg.target_green > ctm_pkg::FX_ONE) ? ctm_pkg::FX_ONE : cfg.target_green;
   assign target[2] = (cfg.target_blue  > ctm_pkg::FX_ONE) ? ctm_pkg::FX_ONE : cfg.target_blue;

   always_comb begin
      dist_in = work.alpha_dist;
      for (int ch = 0; ch < 3; ch++) begin
         if (work.zero_alpha) begin
            pix[ch] = 16'd0;
         end else if (work.lane[ch].sat) begin
            pix[ch] = ctm_pkg::FX_ONE;
         end else begin
            pix[ch] = {1'b0, work.lane[ch].quo};
         end
         diff[ch] = (pix[ch] > target[ch]) ? 16'(pix[ch] - target[ch])
                                           : 16'(target[ch] - pix[ch]);
         if (diff[ch] > dist_in) begin
            dist_in = diff[ch];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         dist_ff     <= dist_in;
         alpha_ok_ff <= work.alpha_ok;
         dest_col_ff <= work.dest_col;
         dest_row_ff <= work.dest_row;
      end
   end

   always_comb begin
      if (ctm_pkg::COLOR_TOLERANCE > 0) begin
         hit = ({2'b00, dist_ff} << 1) < ctm_pkg::TOL_LIMIT;
      end else begin
         hit = (dist_ff == 16'd0);
      end
      write             = alpha_ok_ff && (hit ^ cfg.invert_match);
      rsp_in.write_mark = write;
      rsp_in.mark_byte  = write ? cfg.mark_value : 8'd0;
      rsp_in.dest_col   = dest_col_ff;
      rsp_in.dest_row   = dest_row_ff;
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

`default_nettype wire

@@ rtl/core/color_tolerance_mask.sv @@
// Top level of the color tolerance mask: config port, six-stage pixel pipeline.
// Depends on ctm_pkg, ctm_csr, ctm_front, ctm_div_stage and ctm_back.
//
//   channel | ports                         | moves
//   --------+-------------------------------+---------------------------------
//   request | req_valid req_stall req_data  | one pixel with tile position
//   result  | rsp_valid rsp_stall rsp_data  | mark flag, byte, mask position
//   config  | psel penable pwrite paddr ... | eight registers at 4*i
//
// One request per cycle is taken while req_stall is low, and each stage registers it in turn.
// Every stage holds one request, so the rate is one per cycle while rsp_stall is low; the
// restoring divider fills three of the six stages at five quotient bits per stage.
// Synchronous reset clears the stage valid bits and loads the register defaults.
// A stalled stage holds its data; earlier stages keep moving into empty slots.
`default_nettype none

module color_tolerance_mask (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ctm_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ctm_pkg::rsp_type       rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [4:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output logic                   pready
);

   localparam int LAST = ctm_pkg::NUM_STAGES - 1;

   ctm_pkg::cfg_type      cfg;
   ctm_pkg::div_work_type work [ctm_pkg::DIV_STAGES + 1];
   logic [LAST:0]         valid_ff;
   logic [LAST:0]         valid_in;
   logic [LAST:0]         adv;

   ctm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   always_comb begin
      adv[LAST] = !valid_ff[LAST] || !rsp_stall;
      for (int k = LAST - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k + 1];
      end
      for (int k = 0; k <= LAST; k++) begin
         if (adv[k]) begin
            valid_in[k] = (k == 0) ? req_valid : valid_ff[(k == 0) ? 0 : k - 1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = valid_ff[LAST];

   ctm_front u_front (
      .clock (clock),
      .load  (adv[0]),
      .req   (req_data),
      .cfg   (cfg),
      .work  (work[0])
   );

   for (genvar g = 0; g < ctm_pkg::DIV_STAGES; g++) begin : g_div
      ctm_div_stage u_div (
         .clock  (clock),
         .load   (adv[g + 1]),
         .work_i (work[g]),
         .work_o (work[g + 1])
      );
   end

   ctm_back u_back (
      .clock (clock),
      .load  (adv[LAST:LAST - 1]),
      .work  (work[ctm_pkg::DIV_STAGES]),
      .cfg   (cfg),
      .rsp   (rsp_data)
   );

endmodule

`default_nettype wire
